>>> design/cte_pkg.sv
// ============================================================================
// cte_pkg
// shared types and codes for the capability table engine
// ============================================================================
package cte_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_GRANT  = 2'd1,
    OP_REVOKE = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam int unsigned TOKEN_OUT_W = 12;

  // payload of one table entry
  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] target;
    logic [63:0] rights;
  } entry_t;

  // control from the sequencer to the table memories
  typedef struct packed {
    logic rd_en;   // read both memories at the read address
    logic v_we;    // write the valid memory
    logic v_wbit;  // value written to the valid memory
    logic d_we;    // write the entry memory
  } tbl_ctl_t;

endpackage

>>> design/cte_table.sv
// ============================================================================
// cte_table
// valid-mark memory and entry memory, one read and one write port each
// ============================================================================
module cte_table #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                             clk,
  input  cte_pkg::tbl_ctl_t                ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   raddr,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   waddr,
  input  cte_pkg::entry_t                  wdata,
  output logic                             v_rdata,
  output cte_pkg::entry_t                  d_rdata
);
  import cte_pkg::*;

  logic   vmem [TABLE_DEPTH];
  entry_t dmem [TABLE_DEPTH];

  // valid marks: contents are qualified by the fill count, not cleared at reset; revoke writes a zero
  always_ff @(posedge clk) begin
    if (ctl.v_we) begin
      vmem[waddr] <= ctl.v_wbit;
    end
    if (ctl.rd_en) begin
      v_rdata <= vmem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.d_we) begin
      dmem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      d_rdata <= dmem[raddr];
    end
  end

endmodule

>>> design/cte_ctrl.sv
// ============================================================================
// cte_ctrl
// operation sequencer, slot allocator and result register
// ============================================================================
module cte_ctrl #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             operation,
  input  logic [15:0]                            token_in,
  input  logic [31:0]                            owner_id,
  input  logic [31:0]                            target_id,
  input  logic [63:0]                            rights_req,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [cte_pkg::TOKEN_OUT_W-1:0]        token_out,
  output cte_pkg::tbl_ctl_t                      ctl,
  output logic [$clog2(TABLE_DEPTH)-1:0]         raddr,
  output logic [$clog2(TABLE_DEPTH)-1:0]         waddr,
  output cte_pkg::entry_t                        wdata,
  input  logic                                   v_rdata,
  input  cte_pkg::entry_t                        d_rdata
);
  import cte_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam logic [16:0] DEPTH_17 = 17'(TABLE_DEPTH);
  localparam logic [SW-1:0] DEPTH_SW = SW'(TABLE_DEPTH);

  state_t state, state_next;

  // captured item
  logic [1:0]  op;
  logic [15:0] tok;
  logic [31:0] owner;
  logic [31:0] target;
  logic [63:0] rights;

  logic [SW-1:0] next_slot, next_slot_next;
  logic          done_next;
  status_t       status_next;
  logic [TOKEN_OUT_W-1:0] token_out_next;

  logic in_range;
  logic src_live;
  logic full;

  assign busy  = (state == S_EXEC);
  assign raddr = token_in[AW-1:0];

  assign in_range = (tok != 16'd0) && ({1'b0, tok} < DEPTH_17);
  // entries at or above the fill count were not written since reset
  assign src_live = in_range && ({1'b0, tok} < 17'(next_slot)) && v_rdata;
  assign full     = (next_slot == DEPTH_SW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_slot <= SW'(1);
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      next_slot <= next_slot_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op     <= operation;
      tok    <= token_in;
      owner  <= owner_id;
      target <= target_id;
      rights <= rights_req;
    end
    if (done_next) begin
      status    <= status_next;
      token_out <= token_out_next;
    end
  end

  always_comb begin
    state_next     = state;
    next_slot_next = next_slot;
    done_next      = 1'b0;
    status_next    = ST_INVALID;
    token_out_next = '0;
    ctl            = '0;
    waddr          = next_slot[AW-1:0];
    wdata          = '{owner: owner, target: target, rights: rights};

    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.rd_en  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        unique case (op_t'(op))
          OP_CREATE: begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              status_next    = ST_OK;
              token_out_next = TOKEN_OUT_W'(next_slot);
              ctl.d_we       = 1'b1;
              ctl.v_we       = 1'b1;
              ctl.v_wbit     = 1'b1;
              next_slot_next = SW'(next_slot + 1'b1);
            end
          end
          OP_GRANT: begin
            wdata = '{owner: d_rdata.owner, target: target,
                      rights: rights & d_rdata.rights};
            if (!src_live) begin
              status_next = ST_INVALID;
            end else if (full) begin
              status_next = ST_FULL;
            end else begin
              status_next    = ST_OK;
              token_out_next = TOKEN_OUT_W'(next_slot);
              ctl.d_we       = 1'b1;
              ctl.v_we       = 1'b1;
              ctl.v_wbit     = 1'b1;
              next_slot_next = SW'(next_slot + 1'b1);
            end
          end
          OP_REVOKE: begin
            waddr = tok[AW-1:0];
            if (in_range) begin
              status_next = ST_OK;
              ctl.v_we    = 1'b1;
              ctl.v_wbit  = 1'b0;
            end
          end
          default: begin
            status_next = ST_INVALID;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // every accepted item gives its result with done high
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result");

  // allocator stays between 1 and the depth
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (next_slot != '0) && (next_slot <= DEPTH_SW))
    else $error("slot allocator out of range");

  // the allocator only advances on an ok create or grant
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    (next_slot != $past(next_slot)) |-> (done && (status == ST_OK) && (token_out != '0)))
    else $error("allocator moved without an allocation");

  // a failed item never hands out a token
  a_fail_no_token: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (token_out == '0))
    else $error("token returned with a failing status");

endmodule

>>> design/capability_table_engine.sv
// ============================================================================
// capability_table_engine
// capability table with create, grant (rights delegation) and revoke
// ============================================================================
// Pulse start with an item while busy is low; the item is taken at that edge.
// For every item, the accept edge issues a read of the entry named
// by token_in, and the following cycle checks it, writes the table and loads
// the result, which appears on status and token_out with done high for exactly
// one cycle. busy is high in the cycle between, so no item is taken while the
// last is executing; a new item may be started in the same cycle that done is
// shown. This spacing is set by the read-then-write on the registered-read
// table memories. Results cannot be held off: sample them while done is high.
// After reset the block is ready at once: there is no clearing pass, because an
// entry counts as valid only below the allocation count and with its valid
// mark set. token_out carries the low 12 bits of the new token.
module capability_table_engine #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] token_in,
  input  logic [31:0] owner_id,
  input  logic [31:0] target_id,
  input  logic [63:0] rights_req,
  output logic        done,
  output logic [1:0]  status,
  output logic [11:0] token_out
);
  import cte_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // table access from the sequencer
  tbl_ctl_t          ctl;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic              v_rdata;
  entry_t            d_rdata;

  // sequencer: captures the item, decides, writes back and registers the result
  cte_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .token_in   (token_in),
    .owner_id   (owner_id),
    .target_id  (target_id),
    .rights_req (rights_req),
    .done       (done),
    .status     (status),
    .token_out  (token_out),
    .ctl        (ctl),
    .raddr      (raddr),
    .waddr      (waddr),
    .wdata      (wdata),
    .v_rdata    (v_rdata),
    .d_rdata    (d_rdata)
  );

  // table storage: valid marks and entry payloads in two memories; a write
  // always lands before the next item's read, so no forwarding
  cte_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .ctl     (ctl),
    .raddr   (raddr),
    .waddr   (waddr),
    .wdata   (wdata),
    .v_rdata (v_rdata),
    .d_rdata (d_rdata)
  );

endmodule
